// ===== src/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

   localparam int DEF_ROWS = 25;
   localparam int DEF_COLS = 80;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_SETCUR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] BLANK_CHAR     = 8'h20;
   localparam logic [7:0] BLANK_ATTR     = 8'h07;
   localparam logic [15:0] BLANK_CELL    = {BLANK_ATTR, BLANK_CHAR};

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic clear;
      logic capture;
      logic exec;
      logic scroll;
      logic load;
   } tcw_cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic cnt_end;
      logic scroll_req;
   } tcw_status_type;

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/tcw_ctrl.sv =====
`default_nettype none

module tcw_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire tcw_pkg::tcw_status_type sts,
   output tcw_pkg::tcw_cmd_type         cmd
);

   import tcw_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free);
   assign rsp_tvalid  = rsp_valid_ff;

   always_comb begin
      cmd.clear   = (state_ff == S_CLEAR);
      cmd.capture = req_tvalid && req_tready;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.scroll  = (state_ff == S_SCROLL);
      cmd.load    = (state_ff == S_DONE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (sts.cnt_last) state_in = S_IDLE;
         S_IDLE:   if (cmd.capture) state_in = S_EXEC;
         S_EXEC:   state_in = sts.scroll_req ? S_SCROLL : S_DONE;
         S_SCROLL: if (sts.cnt_end) state_in = S_DONE;
         S_DONE: begin
            if (cmd.load) begin
               state_in = cmd.capture ? S_EXEC : S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/tcw_datapath.sv =====
`default_nettype none

module tcw_datapath #(
   parameter int ROWS = tcw_pkg::DEF_ROWS,
   parameter int COLS = tcw_pkg::DEF_COLS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic      [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire tcw_pkg::tcw_cmd_type         cmd,
   output tcw_pkg::tcw_status_type           sts
);

   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS);
   localparam int CLW   = $clog2(COLS);

   function automatic logic [AW-1:0] lin_addr(input logic [RW-1:0] r, input logic [CLW-1:0] c);
      lin_addr = AW'(AW'(r) * AW'(COLS) + AW'(c));
   endfunction

   logic [1:0]     in_cmd_ff;
   logic [7:0]     in_char_ff, in_attr_ff;
   logic [4:0]     in_row_ff;
   logic [6:0]     in_col_ff;

   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [CLW-1:0] cur_col_ff, cur_col_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rd_ok_ff, scr_ff;

   logic [10:0]    out_cur_ff;
   logic [7:0]     out_char_ff, out_attr_ff;
   logic           out_scr_ff;

   logic           we, re;
   logic [AW-1:0]  waddr, raddr, cur_lin, tgt_lin;
   logic [15:0]    wdata, rdata;

   logic           in_range, is_nl, is_bs, last_row, last_col, cur_zero;
   logic [RW-1:0]  tgt_row;
   logic [CLW-1:0] tgt_col;

   assign in_range = (int'(in_row_ff) < ROWS) && (int'(in_col_ff) < COLS);
   assign tgt_row  = RW'(in_row_ff);
   assign tgt_col  = CLW'(in_col_ff);
   assign cur_lin  = lin_addr(cur_row_ff, cur_col_ff);
   assign tgt_lin  = lin_addr(tgt_row, tgt_col);
   assign is_nl    = (in_char_ff == CHAR_NEWLINE);
   assign is_bs    = (in_char_ff == CHAR_BACKSPACE);
   assign last_row = (cur_row_ff == RW'(ROWS - 1));
   assign last_col = (cur_col_ff == CLW'(COLS - 1));
   assign cur_zero = (cur_row_ff == '0) && (cur_col_ff == '0);

   always_comb begin
      sts.cnt_last   = (cnt_ff == CW'(CELLS - 1));
      sts.cnt_end    = (cnt_ff == CW'(CELLS));
      sts.scroll_req = (in_cmd_ff == CMD_PUT) && last_row &&
                       (is_nl || (!is_bs && last_col));
   end

   always_comb begin
      we         = 1'b0;
      waddr      = cur_lin;
      wdata      = {in_attr_ff, in_char_ff};
      re         = 1'b0;
      raddr      = tgt_lin;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      cnt_in     = cnt_ff;
      if (cmd.clear) begin
         we     = 1'b1;
         waddr  = AW'(cnt_ff);
         wdata  = BLANK_CELL;
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.scroll) begin
         // read runs one count ahead of the write and fetches the cell COLS further on
         we     = (cnt_ff != '0);
         waddr  = AW'(cnt_ff - CW'(1));
         wdata  = (int'(cnt_ff) <= CELLS - COLS) ? rdata : BLANK_CELL;
         re     = (int'(cnt_ff) < CELLS - COLS);
         raddr  = AW'(cnt_ff + CW'(COLS));
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.exec) begin
         cnt_in = '0;
         unique case (in_cmd_ff)
            CMD_PUT: begin
               if (is_nl) begin
                  cur_col_in = '0;
                  if (!last_row) cur_row_in = cur_row_ff + RW'(1);
               end else if (is_bs) begin
                  if (!cur_zero) begin
                     we    = 1'b1;
                     waddr = cur_lin - AW'(1);
                     wdata = BLANK_CELL;
                     if (cur_col_ff == '0) begin
                        cur_col_in = CLW'(COLS - 1);
                        cur_row_in = cur_row_ff - RW'(1);
                     end else begin
                        cur_col_in = cur_col_ff - CLW'(1);
                     end
                  end
               end else begin
                  we = 1'b1;
                  if (last_col) begin
                     cur_col_in = '0;
                     if (!last_row) cur_row_in = cur_row_ff + RW'(1);
                  end else begin
                     cur_col_in = cur_col_ff + CLW'(1);
                  end
               end
            end
            CMD_WRITE: begin
               we    = in_range;
               waddr = tgt_lin;
            end
            CMD_SETCUR: begin
               if (in_range) begin
                  cur_row_in = tgt_row;
                  cur_col_in = tgt_col;
               end
            end
            CMD_READ: re = in_range;
            default: ;
         endcase
      end
   end

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (re),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         cnt_ff     <= '0;
         rd_ok_ff   <= 1'b0;
         scr_ff     <= 1'b0;
      end else begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         cnt_ff     <= cnt_in;
         if (cmd.exec) begin
            rd_ok_ff <= (in_cmd_ff == CMD_READ) && in_range;
            scr_ff   <= sts.scroll_req;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_cmd_ff  <= req_tdata[1:0];
         in_char_ff <= req_tdata[9:2];
         in_attr_ff <= req_tdata[17:10];
         in_row_ff  <= req_tdata[22:18];
         in_col_ff  <= req_tdata[29:23];
      end
      if (cmd.load) begin
         out_cur_ff  <= 11'(cur_lin);
         out_char_ff <= rd_ok_ff ? rdata[7:0] : 8'h00;
         out_attr_ff <= rd_ok_ff ? rdata[15:8] : 8'h00;
         out_scr_ff  <= scr_ff;
      end
   end

   assign rsp_tdata = {4'h0, out_scr_ff, out_attr_ff, out_char_ff, out_cur_ff};

endmodule

`default_nettype wire

// ===== src/text_console_writer_core.sv =====
`default_nettype none

// Text console over a ROWS x COLS cell RAM (character in the low byte,
// attribute in the high byte) with a linear cursor row*COLS+col. One request
// word gives one response word. After reset the core runs a clearing pass
// that blanks every cell to 0x0720; req_tready stays low until it ends. A
// command then passes an execute state against the single-write-port cell
// RAM and a done state that registers the result once the response register
// is free (a cell read comes back from the RAM's registered read in the done
// state). A put or newline that moves past the last row scrolls the store,
// which streams every cell through the RAM once before the done state.
module text_console_writer_core #(
   parameter int ROWS = tcw_pkg::DEF_ROWS,
   parameter int COLS = tcw_pkg::DEF_COLS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // cmd[1:0], char_code[9:2], attribute[17:10], row_index[22:18],
   // column_index[29:23], zero[31:30]
   input  wire logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // cursor_pos[10:0], read_char[18:11], read_attribute[26:19],
   // scrolled[27], zero[31:28]
   output logic      [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type sts;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tcw_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.exec, cmd.scroll, cmd.load}))
      else $error("more than one datapath phase active");

   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.capture))
      else $error("execute without a captured word");

   a_scroll_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.scroll && sts.cnt_end |=> !cmd.scroll)
      else $error("scroll ran past the last cell");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load))
      else $error("response raised without a load");

endmodule

`default_nettype wire
